[design/cpu_port_and_memory_map_decoder_macros.svh]
// Assertion macros used by the checker of the bus decoder.
`ifndef CPU_PORT_AND_MEMORY_MAP_DECODER_MACROS_SVH
`define CPU_PORT_AND_MEMORY_MAP_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPMD_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("decoder assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CPMD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("decoder assertion failed");

`endif

[design/cpmd_pkg.sv]
`timescale 1ns / 1ps

package cpmd_pkg;

  localparam int unsigned AddrW   = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned TargetW = 4;

  localparam int unsigned InDataW  = 24;  // address, write_data
  localparam int unsigned InUserW  = 1;   // func
  localparam int unsigned OutDataW = 32;  // offset, read_data, motor, record, pad
  localparam int unsigned OutUserW = 5;   // target, read_data_valid

  localparam logic [ByteW-1:0] PortDirReset  = 8'h2f;
  localparam logic [ByteW-1:0] PortDataReset = 8'h37;
  localparam logic [ByteW-1:0] PortReadMask  = 8'hef;
  localparam logic [ByteW-1:0] MotorOffBit   = 8'h10;
  localparam logic [ByteW-1:0] LocalFill     = 8'hff;

  typedef enum logic [TargetW-1:0] {
    TGT_RAM    = 4'd0,
    TGT_BASIC  = 4'd1,
    TGT_KERNAL = 4'd2,
    TGT_CHAR   = 4'd3,
    TGT_VIC    = 4'd4,
    TGT_SID    = 4'd5,
    TGT_COLOR  = 4'd6,
    TGT_CIA1   = 4'd7,
    TGT_CIA2   = 4'd8,
    TGT_IO1    = 4'd9,
    TGT_IO2    = 4'd10,
    TGT_PORT   = 4'd11
  } target_e;

endpackage

[design/cpu_port_and_memory_map_decoder.sv]
// Channel   Dir  tdata (low bit up)                                   tuser
// s_axis    in   address[15:0], write_data[23:16]                     func
// m_axis    out  target_offset[15:0], read_data[23:16],               target[3:0],
//                tape_motor_on[24], tape_record_high[25], zero pad    read_data_valid[4]
//
// One item per cycle while the output is not stalled: an accepted access is decoded
// in the same cycle and its result lands in the output register on the next edge.
// The port registers update on acceptance, so the next access already sees them.
// Reset restores direction 0x2f, data 0x37 and clears the tape flags and the output valid.
// A stalled output holds; the input is taken whenever the output register is
// empty or being drained.
`timescale 1ns / 1ps

module cpu_port_and_memory_map_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [cpmd_pkg::InDataW-1:0]   s_axis_tdata,   // address, write_data
  input  logic [cpmd_pkg::InUserW-1:0]   s_axis_tuser,   // func
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [cpmd_pkg::OutDataW-1:0]  m_axis_tdata,   // offset, read_data, motor, record
  output logic [cpmd_pkg::OutUserW-1:0]  m_axis_tuser    // target, read_data_valid
);
  import cpmd_pkg::*;

  logic               accept;
  logic               wr;
  logic [AddrW-1:0]   addr;
  logic [ByteW-1:0]   wdata;

  logic [ByteW-1:0]   dir_q, dir_d;
  logic [ByteW-1:0]   data_q, data_d;
  logic               motor_q, motor_d;
  logic               rec_q, rec_d;

  target_e            tgt;
  logic [AddrW-1:0]   off;
  logic [ByteW-1:0]   rd;
  logic               rv;
  logic [ByteW-1:0]   merged;
  logic [3:0]         io_page;

  logic               vld_q;
  logic [OutDataW-1:0] odata_q;
  logic [OutUserW-1:0] ouser_q;

  assign wr    = s_axis_tuser[0];
  assign addr  = s_axis_tdata[AddrW-1:0];
  assign wdata = s_axis_tdata[AddrW +: ByteW];

  assign s_axis_tready = !vld_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign merged  = wdata & dir_q;
  assign io_page = addr[11:8];

  // Port register updates.
  always_comb begin
    dir_d   = dir_q;
    data_d  = data_q;
    motor_d = motor_q;
    rec_d   = rec_q;
    if (accept && wr && addr[AddrW-1:1] == '0) begin
      if (!addr[0]) begin
        dir_d = wdata;
      end else begin
        data_d  = (data_q & ~dir_q) | merged;
        rec_d   = merged[3];
        motor_d = !merged[5];
      end
    end
  end

  // Address decode against the current banking bits.
  always_comb begin
    tgt = TGT_RAM;
    off = addr;
    rd  = '0;
    rv  = 1'b0;
    if (addr[AddrW-1:1] == '0) begin
      tgt = TGT_PORT;
      if (!wr) begin
        rv = 1'b1;
        if (!addr[0]) begin
          rd = dir_q;
        end else begin
          rd = (data_q & PortReadMask) | (motor_q ? '0 : MotorOffBit);
        end
      end
    end else if (addr[15:13] == 3'b101) begin
      if (data_q[0] && data_q[1] && !wr) begin
        tgt = TGT_BASIC;
        off = {3'b000, addr[12:0]};
      end
    end else if (addr[15:12] == 4'hd) begin
      // With LORAM and HIRAM both clear the whole area is RAM.
      if (data_q[0] || data_q[1]) begin
        if (data_q[2]) begin
          unique case (io_page)
            4'h0, 4'h1, 4'h2, 4'h3: begin
              tgt = TGT_VIC;
              off = {10'd0, addr[5:0]};
            end
            4'h4, 4'h5, 4'h6, 4'h7: begin
              tgt = TGT_SID;
              off = '0;
            end
            4'h8, 4'h9, 4'ha, 4'hb: begin
              tgt = TGT_COLOR;
              off = {6'd0, addr[9:0]};
            end
            4'hc: begin
              tgt = TGT_CIA1;
              off = {8'd0, addr[7:0]};
            end
            4'hd: begin
              tgt = TGT_CIA2;
              off = {8'd0, addr[7:0]};
            end
            4'he: begin
              tgt = TGT_IO1;
              off = '0;
            end
            default: begin
              tgt = TGT_IO2;
              off = '0;
            end
          endcase
          if (!wr && (tgt == TGT_SID || tgt == TGT_IO1 || tgt == TGT_IO2)) begin
            rd = LocalFill;
            rv = 1'b1;
          end
        end else if (!wr) begin
          tgt = TGT_CHAR;
          off = {5'd0, addr[10:0]};
        end
      end
    end else if (addr[15:13] == 3'b111) begin
      if (data_q[1] && !wr) begin
        tgt = TGT_KERNAL;
        off = {3'b000, addr[12:0]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= PortDirReset;
      data_q  <= PortDataReset;
      motor_q <= 1'b0;
      rec_q   <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      dir_q   <= dir_d;
      data_q  <= data_d;
      motor_q <= motor_d;
      rec_q   <= rec_d;
      if (accept) begin
        vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      odata_q <= {{(OutDataW - AddrW - ByteW - 2){1'b0}}, rec_d, motor_d, rd, off};
      ouser_q <= {rv, tgt};
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

endmodule

[design/cpmd_checker.sv]
`timescale 1ns / 1ps
`include "cpu_port_and_memory_map_decoder_macros.svh"

module cpmd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [cpmd_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic [cpmd_pkg::OutUserW-1:0]  m_axis_tuser
);
  import cpmd_pkg::*;

  logic [TargetW-1:0] tgt;
  logic               rv;

  assign tgt = m_axis_tuser[TargetW-1:0];
  assign rv  = m_axis_tuser[TargetW];

  // A held result keeps its value until taken.
  `CPMD_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // An accepted access always yields a result on the next cycle.
  `CPMD_ASSERT_NEXT(a_result, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, m_axis_tvalid)

  // Only the port and the unconnected areas answer locally.
  `CPMD_ASSERT_SAME(a_local, clk_i, rst_ni, m_axis_tvalid && rv, tgt == TGT_PORT || tgt == TGT_SID || tgt == TGT_IO1 || tgt == TGT_IO2)

  // The port sits at addresses 0 and 1 only.
  `CPMD_ASSERT_SAME(a_port, clk_i, rst_ni, m_axis_tvalid && tgt == TGT_PORT, m_axis_tdata[15:1] == '0)

endmodule

bind cpu_port_and_memory_map_decoder cpmd_checker u_cpmd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
